// ----- rtl/atl_pkg.sv -----
package atl_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_BANG      = 8'h21;
    localparam logic [7:0] CHAR_DOLLAR    = 8'h24;
    localparam logic [7:0] CHAR_AMP       = 8'h26;
    localparam logic [7:0] CHAR_LPAREN    = 8'h28;
    localparam logic [7:0] CHAR_RPAREN    = 8'h29;
    localparam logic [7:0] CHAR_PLUS      = 8'h2B;
    localparam logic [7:0] CHAR_MINUS     = 8'h2D;
    localparam logic [7:0] CHAR_DOT       = 8'h2E;
    localparam logic [7:0] CHAR_SLASH     = 8'h2F;
    localparam logic [7:0] CHAR_SEMICOLON = 8'h3B;
    localparam logic [7:0] CHAR_EQUALS    = 8'h3D;
    localparam logic [7:0] CHAR_AT        = 8'h40;
    localparam logic [7:0] CHAR_UNDERLINE = 8'h5F;
    localparam logic [7:0] CHAR_PIPE      = 8'h7C;

    localparam logic [15:0] LINE_MAX = 16'hFFFF;

    typedef enum logic [3:0] {
        KIND_ID        = 4'd0,
        KIND_AT        = 4'd1,
        KIND_EQUALS    = 4'd2,
        KIND_SEMICOLON = 4'd3,
        KIND_NEWLINE   = 4'd4,
        KIND_LPAREN    = 4'd5,
        KIND_RPAREN    = 4'd6,
        KIND_MINUS     = 4'd7,
        KIND_PLUS      = 4'd8,
        KIND_NOT       = 4'd9,
        KIND_OR        = 4'd10,
        KIND_AND       = 4'd11,
        KIND_EOF       = 4'd12,
        KIND_ERROR     = 4'd13
    } token_kind_t;

    typedef struct packed {
        token_kind_t kind;
        logic [7:0]  text;
        logic [5:0]  position;
        logic        token_end;
        logic        too_long;
        logic [15:0] line;
        logic        final_result;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } result_pair_t;

    function automatic logic id_byte(input logic [7:0] c);
        logic is_lower;
        logic is_upper;
        logic is_digit;
        is_lower = (c >= 8'h61) && (c <= 8'h7A);
        is_upper = (c >= 8'h41) && (c <= 8'h5A);
        is_digit = (c >= 8'h30) && (c <= 8'h39);
        return is_lower || is_upper || is_digit || (c == CHAR_UNDERLINE) ||
               (c == CHAR_DOT) || (c == CHAR_DOLLAR);
    endfunction

    function automatic token_kind_t op_kind(input logic [7:0] c);
        token_kind_t k;
        unique case (c)
            CHAR_AT:        k = KIND_AT;
            CHAR_EQUALS:    k = KIND_EQUALS;
            CHAR_SEMICOLON: k = KIND_SEMICOLON;
            CHAR_NEWLINE:   k = KIND_NEWLINE;
            CHAR_LPAREN:    k = KIND_LPAREN;
            CHAR_RPAREN:    k = KIND_RPAREN;
            CHAR_MINUS:     k = KIND_MINUS;
            CHAR_PLUS:      k = KIND_PLUS;
            CHAR_BANG:      k = KIND_NOT;
            CHAR_PIPE:      k = KIND_OR;
            CHAR_AMP:       k = KIND_AND;
            default:        k = KIND_ERROR;
        endcase
        return k;
    endfunction

endpackage

// ----- rtl/assembly_token_lexer.sv -----
// Latency: when the result queue is empty, an accepted item's first result is offered on the m_ side in the next cycle.
// Throughput: one item per cycle while s_tready is high; an item that yields two results gives two m_ transfers.
// s_tready is high while the four-entry result queue has at least two free entries.
// Reset (aresetn low, synchronous) clears the lexer state, the line count and the queue.
// End of file also returns the lexer state and the line count to their reset values.
module assembly_token_lexer #(
    parameter int MAX_ID_POSITION = 63
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // char_code
    input  logic        s_tuser,   // end_of_file
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // token_kind, text_byte, char_position, line_count, zero pad
    output logic        m_tlast,   // token_end
    output logic [1:0]  m_tuser    // too_long, final_result
);

    logic                  take;
    logic                  room;
    atl_pkg::result_pair_t pair;
    atl_pkg::result_t      out_item;

    assign s_tready = room;
    assign take     = s_tvalid && room;

    atl_lexer_core #(
        .MAX_ID_POSITION(MAX_ID_POSITION)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .take       (take),
        .char_code  (s_tdata),
        .end_of_file(s_tuser),
        .pair       (pair)
    );

    atl_result_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .pair     (pair),
        .room     (room),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_item (out_item)
    );

    assign m_tdata = {6'd0, out_item.line, out_item.position, out_item.text, out_item.kind};
    assign m_tlast = out_item.token_end;
    assign m_tuser = {out_item.final_result, out_item.too_long};

endmodule

// ----- rtl/atl_lexer_core.sv -----
module atl_lexer_core #(
    parameter int MAX_ID_POSITION = 63
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  take,
    input  logic [7:0]            char_code,
    input  logic                  end_of_file,
    output atl_pkg::result_pair_t pair
);

    localparam int POS_W = $clog2(MAX_ID_POSITION + 1);

    logic             in_comment_reg, in_comment_next;
    logic             pending_valid_reg, pending_valid_next;
    logic [7:0]       pending_char_reg, pending_char_next;
    logic [POS_W-1:0] pending_position_reg, pending_position_next;
    logic             pending_overflow_reg, pending_overflow_next;
    logic [15:0]      newline_total_reg, newline_total_next;

    logic             flush_valid;
    logic             flush_end;
    logic             tok_valid;
    atl_pkg::token_kind_t tok_kind;
    logic [7:0]       tok_text;
    atl_pkg::result_t flush_res;
    atl_pkg::result_t tok_res;
    logic [15:0]      total_inc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_comment_reg       <= 1'b0;
            pending_valid_reg    <= 1'b0;
            pending_char_reg     <= 8'd0;
            pending_position_reg <= '0;
            pending_overflow_reg <= 1'b0;
            newline_total_reg    <= 16'd0;
        end else if (take) begin
            in_comment_reg       <= in_comment_next;
            pending_valid_reg    <= pending_valid_next;
            pending_char_reg     <= pending_char_next;
            pending_position_reg <= pending_position_next;
            pending_overflow_reg <= pending_overflow_next;
            newline_total_reg    <= newline_total_next;
        end
    end

    assign total_inc = (newline_total_reg != atl_pkg::LINE_MAX) ?
                       newline_total_reg + 16'd1 : newline_total_reg;

    always_comb begin
        in_comment_next       = in_comment_reg;
        pending_valid_next    = pending_valid_reg;
        pending_char_next     = pending_char_reg;
        pending_position_next = pending_position_reg;
        pending_overflow_next = pending_overflow_reg;
        newline_total_next    = newline_total_reg;
        flush_valid           = 1'b0;
        flush_end             = 1'b1;
        tok_valid             = 1'b0;
        tok_kind              = atl_pkg::KIND_EOF;
        tok_text              = 8'd0;

        priority if (end_of_file) begin
            flush_valid           = pending_valid_reg;
            tok_valid             = 1'b1;
            in_comment_next       = 1'b0;
            pending_valid_next    = 1'b0;
            pending_char_next     = 8'd0;
            pending_position_next = '0;
            pending_overflow_next = 1'b0;
            newline_total_next    = 16'd0;
        end else if (in_comment_reg) begin
            if (char_code == atl_pkg::CHAR_NEWLINE) begin
                in_comment_next    = 1'b0;
                newline_total_next = total_inc;
                tok_valid          = 1'b1;
                tok_kind           = atl_pkg::KIND_NEWLINE;
                tok_text           = char_code;
            end
        end else if (atl_pkg::id_byte(char_code)) begin
            if (pending_valid_reg) begin
                flush_valid = 1'b1;
                flush_end   = 1'b0;
                if (pending_position_reg >= POS_W'(MAX_ID_POSITION)) begin
                    pending_position_next = POS_W'(MAX_ID_POSITION);
                    pending_overflow_next = 1'b1;
                end else begin
                    pending_position_next = pending_position_reg + 1'b1;
                end
            end else begin
                pending_position_next = '0;
                pending_overflow_next = 1'b0;
            end
            pending_valid_next = 1'b1;
            pending_char_next  = char_code;
        end else begin
            flush_valid           = pending_valid_reg;
            pending_valid_next    = 1'b0;
            pending_char_next     = 8'd0;
            pending_position_next = '0;
            pending_overflow_next = 1'b0;
            if (char_code == atl_pkg::CHAR_SLASH) begin
                in_comment_next = 1'b1;
            end else if (char_code != atl_pkg::CHAR_SPACE) begin
                tok_valid = 1'b1;
                tok_kind  = atl_pkg::op_kind(char_code);
                tok_text  = char_code;
                if (tok_kind == atl_pkg::KIND_NEWLINE) begin
                    newline_total_next = total_inc;
                end
            end
        end
    end

    always_comb begin
        flush_res.kind         = atl_pkg::KIND_ID;
        flush_res.text         = pending_char_reg;
        flush_res.position     = 6'(pending_position_reg);
        flush_res.token_end    = flush_end;
        flush_res.too_long     = pending_overflow_reg;
        flush_res.line         = newline_total_reg;
        flush_res.final_result = !tok_valid;

        tok_res.kind           = tok_kind;
        tok_res.text           = tok_text;
        tok_res.position       = 6'd0;
        tok_res.token_end      = 1'b1;
        tok_res.too_long       = 1'b0;
        tok_res.line           = end_of_file ? newline_total_reg : newline_total_next;
        tok_res.final_result   = 1'b1;

        pair.count  = take ? ({1'b0, flush_valid} + {1'b0, tok_valid}) : 2'd0;
        pair.first  = flush_valid ? flush_res : tok_res;
        pair.second = tok_res;
    end

    a_eof_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && end_of_file) |=> (!pending_valid_reg && !in_comment_reg &&
                                   newline_total_reg == 16'd0))
        else $error("end of file did not clear the lexer state");

    a_pair_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (pair.count == 2'd2) |-> (pair.first.kind == atl_pkg::KIND_ID &&
                                  !pair.first.final_result))
        else $error("two results without a leading identifier flush");

    a_lines_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && !end_of_file) |=> (newline_total_reg >= $past(newline_total_reg)))
        else $error("line count went backward without end of file");

endmodule

// ----- rtl/atl_result_fifo.sv -----
module atl_result_fifo (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  atl_pkg::result_pair_t pair,
    output logic                  room,
    output logic                  out_valid,
    input  logic                  out_ready,
    output atl_pkg::result_t      out_item
);

    atl_pkg::result_t entry_reg [atl_pkg::FIFO_DEPTH];

    logic [atl_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [atl_pkg::FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [atl_pkg::FIFO_CNT_W-1:0] count_reg, count_next;
    logic                           rd;

    assign rd        = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign out_item  = entry_reg[rd_ptr_reg];
    assign room      = (count_reg <= atl_pkg::FIFO_CNT_W'(atl_pkg::FIFO_DEPTH - 2));

    always_comb begin
        wr_ptr_next = wr_ptr_reg + atl_pkg::FIFO_PTR_W'(pair.count);
        rd_ptr_next = rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + atl_pkg::FIFO_CNT_W'(pair.count) -
                      atl_pkg::FIFO_CNT_W'(rd);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pair.count != 2'd0) begin
            entry_reg[wr_ptr_reg] <= pair.first;
        end
        if (pair.count == 2'd2) begin
            entry_reg[wr_ptr_reg + 1'b1] <= pair.second;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= atl_pkg::FIFO_CNT_W'(atl_pkg::FIFO_DEPTH))
        else $error("result queue count beyond depth");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, count_reg} + {2'b00, pair.count}) <= (atl_pkg::FIFO_CNT_W + 1)'(atl_pkg::FIFO_DEPTH))
        else $error("result queue written without room");

    a_double_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (pair.count == 2'd2 && !rd) |=> (count_reg == $past(count_reg) + 3'd2))
        else $error("double write not counted");

endmodule
